[hw/rtl/lph_pkg.sv]
`timescale 1ns / 1ps

package lph_pkg;

    // Table size is a power of two so the home slot is the low key bits.
    localparam int SLOT_BITS  = 4;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;

    localparam int KEY_W   = 40;
    localparam int NAME_W  = 64;
    localparam int PROBE_W = 5;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 2;

    localparam int PROBE_MAX = (1 << PROBE_W) - 1;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_FOUND     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PROBE = 1'b1
    } t_state;

    function automatic logic [PROBE_W-1:0] sat_probe(input logic [SLOT_BITS:0] n);
        int v;
        v = int'(n);
        if (v > PROBE_MAX) begin
            return PROBE_W'(PROBE_MAX);
        end
        return PROBE_W'(n);
    endfunction

endpackage

[hw/rtl/linear_probe_hash_table_core.sv]
`timescale 1ns / 1ps
// Throughput: one operation at a time; after the accept cycle, one probe per cycle on
// the key/name memory until the result can enter the output register.
// A finished result waits in an output register while the next item is taken.
// Reset (synchronous, active low) clears the occupied flags and the handshake state;
// key and name memories are not cleared.

module linear_probe_hash_table_core
    import lph_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [KEY_W-1:0]     i_telephone_key,
    input  logic [NAME_W-1:0]    i_name_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [PROBE_W-1:0]   o_probe_count,
    output logic [INDEX_W-1:0]   o_slot_index,
    output logic [NAME_W-1:0]    o_name_found
);

    logic [KEY_W-1:0]     key_mem  [SLOT_COUNT];
    logic [NAME_W-1:0]    name_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_occupied;

    t_state               r_state, n_state;
    t_op                  r_op;
    logic [KEY_W-1:0]     r_key;
    logic [NAME_W-1:0]    r_name;
    logic [SLOT_BITS-1:0] r_pos, n_pos;
    logic [SLOT_BITS:0]   r_step, n_step;
    logic [KEY_W-1:0]     r_key_rd;
    logic [NAME_W-1:0]    r_name_rd;

    logic                 r_out_valid;
    t_status              r_status;
    logic [PROBE_W-1:0]   r_probe_count;
    logic [INDEX_W-1:0]   r_slot_index;
    logic [NAME_W-1:0]    r_name_found;

    logic [SLOT_BITS-1:0] rd_addr;
    logic                 in_xfer;
    logic                 out_free;
    logic                 done;
    logic                 wr_en;
    t_status              res_status;
    logic [PROBE_W-1:0]   res_probes;
    logic [INDEX_W-1:0]   res_slot;
    logic [NAME_W-1:0]    res_name;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_xfer  = i_in_valid && !o_in_stall;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_step     = r_step;
        rd_addr    = r_pos;
        o_in_stall = 1'b1;
        done       = 1'b0;
        wr_en      = 1'b0;
        res_status = STAT_NOT_FOUND;
        res_probes = '0;
        res_slot   = '0;
        res_name   = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                rd_addr    = i_telephone_key[SLOT_BITS-1:0];
                if (i_in_valid) begin
                    n_state = ST_PROBE;
                    n_pos   = i_telephone_key[SLOT_BITS-1:0];
                    n_step  = '0;
                end
            end
            ST_PROBE: begin
                // read data for r_pos arrived this cycle
                if (!r_occupied[r_pos]) begin
                    done       = 1'b1;
                    res_probes = sat_probe(r_step);
                    if (r_op == OP_INSERT) begin
                        res_status = STAT_INSERTED;
                        res_slot   = INDEX_W'(r_pos);
                        wr_en      = out_free;
                    end
                end else if (r_op == OP_SEARCH && r_key_rd == r_key) begin
                    done       = 1'b1;
                    res_status = STAT_FOUND;
                    res_probes = sat_probe(r_step + 1'b1);
                    res_slot   = INDEX_W'(r_pos);
                    res_name   = r_name_rd;
                end else if (r_step == (SLOT_BITS+1)'(SLOT_COUNT - 1)) begin
                    done       = 1'b1;
                    res_status = (r_op == OP_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
                    res_probes = sat_probe(r_step + 1'b1);
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_step  = r_step + 1'b1;
                    rd_addr = r_pos + 1'b1;
                end
                if (done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occupied  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_occupied[r_pos] <= 1'b1;
            end
            if (done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_step <= n_step;
        if (in_xfer) begin
            r_op   <= t_op'(i_operation);
            r_key  <= i_telephone_key;
            r_name <= i_name_value;
        end
        if (done && out_free) begin
            r_status      <= res_status;
            r_probe_count <= res_probes;
            r_slot_index  <= res_slot;
            r_name_found  <= res_name;
        end
    end

    // slot memories: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[r_pos]  <= r_key;
            name_mem[r_pos] <= r_name;
        end
        r_key_rd  <= key_mem[rd_addr];
        r_name_rd <= name_mem[rd_addr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_probe_count = r_probe_count;
    assign o_slot_index  = r_slot_index;
    assign o_name_found  = r_name_found;

endmodule

[tb/sv/linear_probe_hash_table_core_test.sv]
`timescale 1ns / 1ps

module linear_probe_hash_table_core_test;
    import lph_pkg::*;

    localparam int RANDOM_OPS     = 1875;
    localparam int MAX_WAIT       = 17;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        t_status             status;
        logic [PROBE_W-1:0]  probes;
        logic [INDEX_W-1:0]  slot;
        logic [NAME_W-1:0]   name;
    } t_phone_reply;

    typedef struct {
        t_op                 op;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name;
        bit                  fixed;   // reply typed in by hand
        t_phone_reply        reply;
    } t_phone_op;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_operation;
    logic [KEY_W-1:0]     i_telephone_key;
    logic [NAME_W-1:0]    i_name_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [STAT_W-1:0]    o_status;
    logic [PROBE_W-1:0]   o_probe_count;
    logic [INDEX_W-1:0]   o_slot_index;
    logic [NAME_W-1:0]    o_name_found;

    // shadow copy of the table
    logic                 slot_used [SLOT_COUNT];
    logic [KEY_W-1:0]     slot_key  [SLOT_COUNT];
    logic [NAME_W-1:0]    slot_name [SLOT_COUNT];

    t_phone_reply         replies_due[$];
    t_phone_op            directed_ops[$];
    int                   mismatches;
    int                   status_seen [4];
    int                   idle_cycles;
    bit                   sender_burst;
    bit                   receiver_burst;

    linear_probe_hash_table_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_telephone_key (i_telephone_key),
        .i_name_value    (i_name_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_probe_count   (o_probe_count),
        .o_slot_index    (o_slot_index),
        .o_name_found    (o_name_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_phone_reply apply_phone_op(input t_op op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [NAME_W-1:0] name);
        t_phone_reply r;
        int pos;
        int probes;
        int n;
        pos = int'(key % SLOT_COUNT);
        probes = 0;
        r.status = (op == OP_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        r.probes = '0;
        r.slot = '0;
        r.name = '0;
        for (n = 0; n < SLOT_COUNT; n++) begin
            if (!slot_used[pos]) begin
                if (op == OP_INSERT) begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = key;
                    slot_name[pos] = name;
                    r.status = STAT_INSERTED;
                    r.slot   = INDEX_W'(pos);
                end
                r.probes = PROBE_W'(probes);
                return r;
            end
            probes++;
            if (op == OP_SEARCH && slot_key[pos] == key) begin
                r.status = STAT_FOUND;
                r.probes = PROBE_W'(probes);
                r.slot   = INDEX_W'(pos);
                r.name   = slot_name[pos];
                return r;
            end
            pos = (pos + 1) % SLOT_COUNT;
        end
        // whole lap without a free slot or a match
        r.probes = PROBE_W'((probes > PROBE_MAX) ? PROBE_MAX : probes);
        return r;
    endfunction

    task automatic add_row(input t_op op, input logic [KEY_W-1:0] key,
                           input logic [NAME_W-1:0] name, input bit fixed,
                           input t_status st, input int probes, input int slot,
                           input logic [NAME_W-1:0] found);
        t_phone_op row;
        row.op = op;
        row.key = key;
        row.name = name;
        row.fixed = fixed;
        row.reply.status = st;
        row.reply.probes = PROBE_W'(probes);
        row.reply.slot = INDEX_W'(slot);
        row.reply.name = found;
        directed_ops.push_back(row);
    endtask

    task automatic send_op(input t_phone_op row);
        int gap;
        t_phone_reply predicted;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= row.op;
        i_telephone_key <= row.key;
        i_name_value    <= row.name;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // transfer taken at this edge
        predicted = apply_phone_op(row.op, row.key, row.name);
        replies_due.push_back(row.fixed ? row.reply : predicted);
    endtask

    task automatic wait_for_replies;
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string field, input logic [NAME_W-1:0] want,
                               input logic [NAME_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial begin
        t_phone_op row;
        int sel;
        int i;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_operation     <= OP_INSERT;
        i_telephone_key <= '0;
        i_name_value    <= '0;
        mismatches = 0;
        sender_burst = 1'b0;
        foreach (slot_used[k]) slot_used[k] = 1'b0;

        // empty table, extreme keys, collisions and wrap past the last slot
        add_row(OP_SEARCH, '0, '1, 1, STAT_NOT_FOUND, 0, 0, '0);
        add_row(OP_SEARCH, '1, '0, 1, STAT_NOT_FOUND, 0, 0, '0);
        add_row(OP_INSERT, '0, '0, 1, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, '1, '1, 1, STAT_INSERTED, 0, 15, '0);
        add_row(OP_INSERT, 40'd16, "HOME_0_B", 1, STAT_INSERTED, 1, 1, '0);
        add_row(OP_INSERT, 40'd31, "WRAP_TOP", 1, STAT_INSERTED, 3, 2, '0);
        add_row(OP_SEARCH, '1, '0, 1, STAT_FOUND, 1, 15, '1);
        add_row(OP_SEARCH, 40'd31, '0, 0, STAT_INSERTED, 0, 0, '0);
        // duplicate key: search must return the first copy
        add_row(OP_INSERT, '0, "DUP_ZERO", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_SEARCH, '0, '0, 1, STAT_FOUND, 1, 0, '0);
        add_row(OP_SEARCH, 40'd32, '0, 0, STAT_INSERTED, 0, 0, '0);
        // fill the rest of the table
        add_row(OP_INSERT, 40'h00_0000_0005, "ENTRY_01", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h80_0000_0005, "ENTRY_02", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'hAB_CDEF_0127, "ENTRY_03", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h12_3456_789A, "ENTRY_04", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'hFE_DCBA_9873, "ENTRY_05", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h00_0000_000F, "ENTRY_06", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h7F_FFFF_FFF8, "ENTRY_07", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h01_0000_0000, "ENTRY_08", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'hC3_5A5A_A5AC, "ENTRY_09", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h24_6813_579E, "ENTRY_10", 0, STAT_INSERTED, 0, 0, '0);
        add_row(OP_INSERT, 40'h99_9999_9999, "ENTRY_11", 0, STAT_INSERTED, 0, 0, '0);
        // table now full
        add_row(OP_INSERT, 40'h33_3333_3333, "OVERFLOW", 1, STAT_FULL, 16, 0, '0);
        add_row(OP_SEARCH, 40'h55_5555_5555, '0, 1, STAT_NOT_FOUND, 16, 0, '0);
        add_row(OP_SEARCH, 40'h00_0000_000F, '0, 0, STAT_INSERTED, 0, 0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_ops[k]) send_op(directed_ops[k]);
        wait_for_replies();

        for (i = 0; i < RANDOM_OPS; i++) begin
            if (i % 100 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_OPS / 2) wait_for_replies();
            sel = $urandom_range(0, 9);
            row.fixed = 1'b0;
            row.name = {$urandom(), $urandom()};
            row.key = KEY_W'({$urandom(), $urandom()});
            if (sel < 6) begin
                // key already in the table, any probe depth
                row.op = OP_SEARCH;
                row.key = slot_key[$urandom_range(0, SLOT_COUNT - 1)];
            end else if (sel < 8) begin
                row.op = OP_SEARCH;
            end else begin
                row.op = OP_INSERT;
            end
            send_op(row);
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d table operations: %0d inserted, %0d full, %0d found, %0d not found",
                 directed_ops.size() + RANDOM_OPS, status_seen[STAT_INSERTED],
                 status_seen[STAT_FULL], status_seen[STAT_FOUND], status_seen[STAT_NOT_FOUND]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // result side
    initial begin
        t_phone_reply want;
        int hold;
        int taken;
        taken = 0;
        receiver_burst = 1'b0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (taken % 100 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
            hold = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            taken++;
            if (replies_due.size() == 0) begin
                $display("%0t: result with nothing pending, status %0h", $time, o_status);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("probe_count", want.probes, o_probe_count);
                check_field("slot_index", want.slot, o_slot_index);
                check_field("name_found", want.name, o_name_found);
                status_seen[want.status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
